/* rtl/hsl_pkg.sv */
// Shared widths, constants and codes for the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int unsigned PCT_W       = 7;
    localparam int unsigned HUE_W       = 9;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned WGT_W       = 6;
    localparam int unsigned CHROMA_W    = 14;
    localparam int unsigned NUM_W       = 20;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;
    localparam int unsigned PIPE_STAGES = 5;

    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_DATA_W   = 16;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;
    localparam logic [PCT_W-1:0] SAT_RESET     = 7'd100;
    localparam logic [PCT_W-1:0] LIGHT_RESET   = 7'd50;
    localparam logic [HUE_W-1:0] HUE_MAX       = 9'd359;
    localparam logic [HUE_W-1:0] HUE_120       = 9'd120;
    localparam logic [HUE_W-1:0] HUE_240       = 9'd240;

    // Scale factors over the common denominator 600000
    localparam logic [NUM_W-1:0] C_SCALE       = 20'd60;
    localparam logic [NUM_W-1:0] L_SCALE       = 20'd6000;
    localparam logic [NUM_W-1:0] HALF_C_SCALE  = 20'd30;

    // ceil(255 * 2^35 / 600000): exact floor for numerators up to 600000
    localparam logic [RECIP_W-1:0] LEVEL_RECIP = 24'd14602889;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } sector_t;

    typedef enum logic {
        REG_SATURATION,
        REG_LIGHTNESS
    } reg_idx_t;

    typedef struct packed {
        logic [PCT_W-1:0] chroma_pct;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic [WGT_W-1:0] wgt;
        sector_t          sector;
    } st1_t;

    typedef struct packed {
        logic [CHROMA_W-1:0] chroma;
        logic [PCT_W-1:0]    light;
        logic [WGT_W-1:0]    wgt;
        sector_t             sector;
    } st2_t;

    typedef struct packed {
        logic [NUM_W-1:0] c_num;
        logic [NUM_W-1:0] x_num;
        logic [NUM_W-1:0] m_num;
        sector_t          sector;
    } st3_t;

    typedef struct packed {
        logic [NUM_W-1:0] blue;
        logic [NUM_W-1:0] green;
        logic [NUM_W-1:0] red;
    } st4_t;

endpackage

/* rtl/hsl_to_rgb_converter_core.sv */
// HSL to RGB converter: five-stage pipeline with APB register port.
// Each accepted word passes through st1_reg, st2_reg, st3_reg, st4_reg and out_reg.
// Throughput: one hue word per cycle unless the output stalls; the narrowest
// path is the final reciprocal multiply stage, one 20 x 24 multiplier per channel.
// Empty stages fill while the output waits, so stalls only back up when full.
// Reset (rst_n low, asynchronous): pipeline emptied, saturation 100, lightness 50.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_core
    import hsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [8:0] hue_deg, [15:9] zero

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    logic [PCT_W-1:0]       sat_reg;
    logic [PCT_W-1:0]       light_reg;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] en;

    st1_t                   st1_reg, st1_next;
    st2_t                   st2_reg, st2_next;
    st3_t                   st3_reg, st3_next;
    st4_t                   st4_reg, st4_next;
    logic [OUT_DATA_W-1:0]  out_reg, out_next;

    logic [HUE_W-1:0]       hue_in;
    logic [HUE_W-1:0]       hue_c;
    logic [HUE_W-1:0]       r120_w;
    logic [PCT_W-1:0]       r120;
    logic [PCT_W-1:0]       wgt_w;
    logic [PCT_W:0]         twol;
    logic [PCT_W:0]         light_dev;
    logic [PCT_W-1:0]       sat_c;
    logic [PCT_W-1:0]       light_c;

    logic [PROD_W-1:0]      prod_r;
    logic [PROD_W-1:0]      prod_g;
    logic [PROD_W-1:0]      prod_b;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= SAT_RESET;
            light_reg <= LIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SATURATION: sat_reg   <= pwdata[PCT_W-1:0];
                REG_LIGHTNESS:  light_reg <= pwdata[PCT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SATURATION: prdata = CFG_DATA_W'(sat_reg);
            REG_LIGHTNESS:  prdata = CFG_DATA_W'(light_reg);
            default:        prdata = '0;
        endcase
    end

    // Per-stage load enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || m_axis_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: clamps, sector, X weight, chroma percentage
    always_comb
    begin
        hue_in  = s_axis_tdata[HUE_W-1:0];
        hue_c   = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        sat_c   = (sat_reg > PCT_MAX) ? PCT_MAX : sat_reg;
        light_c = (light_reg > PCT_MAX) ? PCT_MAX : light_reg;

        if (hue_c >= HUE_240)
        begin
            r120_w = hue_c - HUE_240;
        end
        else if (hue_c >= HUE_120)
        begin
            r120_w = hue_c - HUE_120;
        end
        else
        begin
            r120_w = hue_c;
        end
        r120  = r120_w[PCT_W-1:0];
        wgt_w = (r120 > 7'd60) ? (7'd120 - r120) : r120;

        if (hue_c >= 9'd300)
        begin
            st1_next.sector = SEC_MAG_RED;
        end
        else if (hue_c >= 9'd240)
        begin
            st1_next.sector = SEC_BLU_MAG;
        end
        else if (hue_c >= 9'd180)
        begin
            st1_next.sector = SEC_CYN_BLU;
        end
        else if (hue_c >= 9'd120)
        begin
            st1_next.sector = SEC_GRN_CYN;
        end
        else if (hue_c >= 9'd60)
        begin
            st1_next.sector = SEC_YEL_GRN;
        end
        else
        begin
            st1_next.sector = SEC_RED_YEL;
        end

        twol      = {light_c, 1'b0};
        light_dev = (twol > 8'd100) ? (twol - 8'd100) : (8'd100 - twol);

        st1_next.chroma_pct = PCT_MAX - light_dev[PCT_W-1:0];
        st1_next.sat        = sat_c;
        st1_next.light      = light_c;
        st1_next.wgt        = wgt_w[WGT_W-1:0];
    end

    // Stage 2: chroma over 10000
    always_comb
    begin
        st2_next.chroma = CHROMA_W'(st1_reg.chroma_pct) * CHROMA_W'(st1_reg.sat);
        st2_next.light  = st1_reg.light;
        st2_next.wgt    = st1_reg.wgt;
        st2_next.sector = st1_reg.sector;
    end

    // Stage 3: C, X and m over 600000
    always_comb
    begin
        st3_next.c_num  = NUM_W'(st2_reg.chroma) * C_SCALE;
        st3_next.x_num  = NUM_W'(st2_reg.chroma) * NUM_W'(st2_reg.wgt);
        st3_next.m_num  = NUM_W'(st2_reg.light) * L_SCALE
                        - NUM_W'(st2_reg.chroma) * HALF_C_SCALE;
        st3_next.sector = st2_reg.sector;
    end

    // Stage 4: sector routing plus offset
    always_comb
    begin
        case (st3_reg.sector)
            SEC_RED_YEL:
            begin
                st4_next.red   = st3_reg.c_num + st3_reg.m_num;
                st4_next.green = st3_reg.x_num + st3_reg.m_num;
                st4_next.blue  = st3_reg.m_num;
            end
            SEC_YEL_GRN:
            begin
                st4_next.red   = st3_reg.x_num + st3_reg.m_num;
                st4_next.green = st3_reg.c_num + st3_reg.m_num;
                st4_next.blue  = st3_reg.m_num;
            end
            SEC_GRN_CYN:
            begin
                st4_next.red   = st3_reg.m_num;
                st4_next.green = st3_reg.c_num + st3_reg.m_num;
                st4_next.blue  = st3_reg.x_num + st3_reg.m_num;
            end
            SEC_CYN_BLU:
            begin
                st4_next.red   = st3_reg.m_num;
                st4_next.green = st3_reg.x_num + st3_reg.m_num;
                st4_next.blue  = st3_reg.c_num + st3_reg.m_num;
            end
            SEC_BLU_MAG:
            begin
                st4_next.red   = st3_reg.x_num + st3_reg.m_num;
                st4_next.green = st3_reg.m_num;
                st4_next.blue  = st3_reg.c_num + st3_reg.m_num;
            end
            default:
            begin
                st4_next.red   = st3_reg.c_num + st3_reg.m_num;
                st4_next.green = st3_reg.m_num;
                st4_next.blue  = st3_reg.x_num + st3_reg.m_num;
            end
        endcase
    end

    // Stage 5: floor(255 * n / 600000) by reciprocal multiply
    always_comb
    begin
        prod_r   = PROD_W'(st4_reg.red)   * PROD_W'(LEVEL_RECIP);
        prod_g   = PROD_W'(st4_reg.green) * PROD_W'(LEVEL_RECIP);
        prod_b   = PROD_W'(st4_reg.blue)  * PROD_W'(LEVEL_RECIP);
        out_next = {prod_b[RECIP_SHIFT +: LEVEL_W],
                    prod_g[RECIP_SHIFT +: LEVEL_W],
                    prod_r[RECIP_SHIFT +: LEVEL_W]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st1_reg <= st1_next;
        end
        if (en[1])
        begin
            st2_reg <= st2_next;
        end
        if (en[2])
        begin
            st3_reg <= st3_next;
        end
        if (en[3])
        begin
            st4_reg <= st4_next;
        end
        if (en[4])
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_axis_tdata  = out_reg;

endmodule

/* rtl/hsl_checker.sv */
// Port-level assertions for the HSL to RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsl_checker
    import hsl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [ADDR_W-1:0]     paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // No output word while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output word valid during reset");

    // A stalled output word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // A ready sink never back-pressures the source
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // With the sink ready throughout, an accepted word appears after the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready)
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("word missing at the pipeline output");

endmodule

bind hsl_to_rgb_converter_core hsl_checker u_hsl_checker (.*);
